// ===== rtl/pol_pkg.sv =====
// Shared types and constants for the priority-ordered identifier list.
// No dependencies; used by pol_ram users and priority_ordered_id_list.
package pol_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   typedef enum logic {
      FUNC_REGISTER = 1'b0,
      FUNC_REMOVE   = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_REMOVED   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      func_type           func;
      logic [31:0]        page_id;
      logic signed [31:0] priority_req;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  position;
      logic [4:0]  entry_count;
   } rsp_type;

   // One stored list entry.
   typedef struct packed {
      logic [31:0]        id;
      logic signed [31:0] prio;
   } entry_type;

endpackage

// ===== rtl/pol_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pol_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/priority_ordered_id_list.sv =====
// Top level: list of identifiers kept ascending by signed priority, held in pol_ram.
// Depends on pol_pkg (types, codes) and pol_ram (entry storage).
//
//   channel    | signals                    | handshake
//   -----------+----------------------------+-------------------------------
//   request    | start, busy, req_data      | taken when start & !busy
//   result     | rsp_valid, rsp_data        | one-cycle strobe, no backpressure
//
// On a full rewrite, busy spans a read-only scan for the identifier (ending early
// on a hit), a decision state, a rewrite pass (at most one RAM read and one RAM
// write per cycle) and a tail write. Full-list and not-found cases end after the
// decision state. The result strobe rises as busy falls.
// Reset empties the list; RAM contents need no clearing. Results cannot stall.
module priority_ordered_id_list #(
   parameter int CAPACITY = pol_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pol_pkg::req_type req_data,
   output logic             rsp_valid,
   output pol_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = $bits(pol_pkg::entry_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_MERGE,
      S_TAIL
   } state_type;

   state_type          state_ff, state_in;
   pol_pkg::req_type   req_ff, req_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic               dv_ff, dv_in;
   logic [CW-1:0]      ridx_ff, ridx_in;
   logic               found_ff, found_in;
   logic [IW-1:0]      del_pos_ff, del_pos_in;
   logic               deleted_ff, deleted_in;
   logic               inserted_ff, inserted_in;
   logic [CW-1:0]      ins_pos_ff, ins_pos_in;
   logic [CW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic               carry_vld_ff, carry_vld_in;
   pol_pkg::entry_type carry_ff, carry_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pol_pkg::rsp_type   rsp_ff, rsp_in;

   logic               ram_wr_en;
   logic [IW-1:0]      ram_wr_addr;
   logic [EW-1:0]      ram_wr_data;
   logic               ram_rd_en;
   logic [IW-1:0]      ram_rd_addr;
   logic [EW-1:0]      ram_rd_data;

   pol_pkg::entry_type rd_entry;
   pol_pkg::entry_type new_entry;
   logic               issue_more;
   logic               is_remove;
   logic               is_del;
   logic [CW-1:0]      final_pos;
   logic [31:0]        pos_wide;
   logic [31:0]        cnt_wide;

   pol_ram #(
      .WIDTH(EW),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rd_entry   = pol_pkg::entry_type'(ram_rd_data);
   assign new_entry  = '{id: req_ff.page_id, prio: req_ff.priority_req};
   assign issue_more = (issue_ff < count_ff);
   assign is_remove  = (req_ff.func == pol_pkg::FUNC_REMOVE);
   assign is_del     = dv_ff && found_ff && !deleted_ff && (ridx_ff[IW-1:0] == del_pos_ff);
   assign final_pos  = inserted_ff ? ins_pos_ff : wr_ptr_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      dv_in        = 1'b0;
      ridx_in      = ridx_ff;
      found_in     = found_ff;
      del_pos_in   = del_pos_ff;
      deleted_in   = deleted_ff;
      inserted_in  = inserted_ff;
      ins_pos_in   = ins_pos_ff;
      wr_ptr_in    = wr_ptr_ff;
      carry_vld_in = carry_vld_ff;
      carry_in     = carry_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = issue_ff[IW-1:0];
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_ptr_ff[IW-1:0];
      ram_wr_data  = carry_ff;
      pos_wide     = '0;
      cnt_wide     = 32'(count_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in     = req_data;
               issue_in   = '0;
               found_in   = 1'b0;
               del_pos_in = '0;
               state_in   = S_SEARCH;
            end
         end

         S_SEARCH: begin
            if (dv_ff && (rd_entry.id == req_ff.page_id)) begin
               found_in   = 1'b1;
               del_pos_in = ridx_ff[IW-1:0];
               state_in   = S_DECIDE;
            end else if (!issue_more && !dv_ff) begin
               state_in = S_DECIDE;
            end else if (issue_more) begin
               ram_rd_en = 1'b1;
               dv_in     = 1'b1;
               ridx_in   = issue_ff;
               issue_in  = issue_ff + CW'(1);
            end
         end

         S_DECIDE: begin
            if (!found_ff && (is_remove || (count_ff == CW'(CAPACITY)))) begin
               rsp_in.status      = is_remove ? pol_pkg::ST_NOT_FOUND : pol_pkg::ST_FULL;
               rsp_in.position    = '0;
               rsp_in.entry_count = cnt_wide[4:0];
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end else begin
               issue_in     = '0;
               wr_ptr_in    = '0;
               carry_vld_in = 1'b0;
               inserted_in  = 1'b0;
               deleted_in   = 1'b0;
               ins_pos_in   = '0;
               state_in     = S_MERGE;
            end
         end

         S_MERGE: begin
            // Stream old entries back in place; writes never pass the read point.
            if (issue_more) begin
               ram_rd_en = 1'b1;
               dv_in     = 1'b1;
               ridx_in   = issue_ff;
               issue_in  = issue_ff + CW'(1);
            end
            if (is_del) begin
               deleted_in = 1'b1;
               if (carry_vld_ff) begin
                  ram_wr_en    = 1'b1;
                  ram_wr_data  = carry_ff;
                  wr_ptr_in    = wr_ptr_ff + CW'(1);
                  carry_vld_in = 1'b0;
               end
            end else if (dv_ff) begin
               if (!is_remove && !inserted_ff && (req_ff.priority_req < rd_entry.prio)) begin
                  inserted_in  = 1'b1;
                  ins_pos_in   = wr_ptr_ff;
                  ram_wr_en    = 1'b1;
                  ram_wr_data  = new_entry;
                  carry_in     = rd_entry;
                  carry_vld_in = 1'b1;
               end else if (carry_vld_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = carry_ff;
                  carry_in    = rd_entry;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = rd_entry;
               end
               wr_ptr_in = wr_ptr_ff + CW'(1);
            end
            if (!issue_more && !dv_ff) begin
               state_in = S_TAIL;
            end
         end

         S_TAIL: begin
            if (carry_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = carry_ff;
            end else if (!is_remove && !inserted_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = new_entry;
            end
            carry_vld_in = 1'b0;
            if (is_remove) begin
               count_in      = count_ff - CW'(1);
               pos_wide      = 32'(del_pos_ff);
               rsp_in.status = pol_pkg::ST_REMOVED;
            end else begin
               count_in      = count_ff + CW'(1) - CW'(found_ff);
               pos_wide      = 32'(final_pos);
               rsp_in.status = pol_pkg::ST_INSERTED;
            end
            cnt_wide           = 32'(count_in);
            rsp_in.position    = pos_wide[3:0];
            rsp_in.entry_count = cnt_wide[4:0];
            rsp_valid_in       = 1'b1;
            state_in           = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         carry_vld_ff <= 1'b0;
         inserted_ff  <= 1'b0;
         deleted_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         carry_vld_ff <= carry_vld_in;
         inserted_ff  <= inserted_in;
         deleted_ff   <= deleted_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      issue_ff   <= issue_in;
      ridx_ff    <= ridx_in;
      del_pos_ff <= del_pos_in;
      ins_pos_ff <= ins_pos_in;
      wr_ptr_ff  <= wr_ptr_in;
      carry_ff   <= carry_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("write hits the entry being read");

   a_carry_after_insert: assert property (@(posedge clock) disable iff (reset)
      carry_vld_ff |-> inserted_ff)
      else $error("carry held without an insertion");

   a_rsp_ends_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of a request");

   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");
`endif

endmodule

// ===== tb/priority_ordered_id_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for priority_ordered_id_list: mirrors the list from accepted requests,
// predicts each response and compares it with the strobed one. Depends on pol_pkg.
module priority_ordered_id_list_checker #(
   parameter int CAPACITY = pol_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  pol_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  pol_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);

   logic [31:0]      list_ids [CAPACITY];
   int               list_prios [CAPACITY];
   int               list_len;
   pol_pkg::rsp_type op_results [$];

   // Applies one request to the mirrored list and returns the response it yields.
   function automatic pol_pkg::rsp_type list_update(pol_pkg::req_type r);
      int               hit;
      int               slot;
      int               i;
      int               prio;
      pol_pkg::rsp_type o;
      hit = -1;
      prio = r.priority_req;
      for (i = 0; i < list_len; i++)
         if (hit < 0 && list_ids[i] == r.page_id) hit = i;
      // both operations drop an existing entry first
      if (hit >= 0) begin
         for (i = hit; i < list_len - 1; i++) begin
            list_ids[i] = list_ids[i + 1];
            list_prios[i] = list_prios[i + 1];
         end
         list_len--;
      end
      o = '0;
      if (r.func == pol_pkg::FUNC_REMOVE) begin
         if (hit >= 0) begin
            o.status = pol_pkg::ST_REMOVED;
            o.position = hit[3:0];
         end else begin
            o.status = pol_pkg::ST_NOT_FOUND;
         end
      end else if (list_len >= CAPACITY) begin
         o.status = pol_pkg::ST_FULL;
      end else begin
         // insert before the first strictly greater priority
         slot = list_len;
         for (i = list_len - 1; i >= 0; i--)
            if (prio < list_prios[i]) slot = i;
         for (i = list_len; i > slot; i--) begin
            list_ids[i] = list_ids[i - 1];
            list_prios[i] = list_prios[i - 1];
         end
         list_ids[slot] = r.page_id;
         list_prios[slot] = prio;
         list_len++;
         o.status = pol_pkg::ST_INSERTED;
         o.position = slot[3:0];
      end
      o.entry_count = list_len[4:0];
      return o;
   endfunction

   always @(posedge clock) begin
      pol_pkg::rsp_type want;
      if (reset) begin
         list_len = 0;
         op_results.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (op_results.size() == 0) begin
               $display("%0t: response with none pending: status=%0d position=%0d count=%0d",
                        $time, rsp_data.status, rsp_data.position, rsp_data.entry_count);
               fail_count++;
            end else begin
               want = op_results.pop_front();
               if (rsp_data.status !== want.status || rsp_data.position !== want.position ||
                   rsp_data.entry_count !== want.entry_count) begin
                  $display("%0t: mismatch: expected status=%0d position=%0d count=%0d,",
                           $time, want.status, want.position, want.entry_count,
                           " got status=%0d position=%0d count=%0d",
                           rsp_data.status, rsp_data.position, rsp_data.entry_count);
                  fail_count++;
               end
            end
         end
         if (start && busy === 1'b0)
            op_results.push_back(list_update(req_data));
      end
      pending = op_results.size();
   end

endmodule

// ===== tb/priority_ordered_id_list_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for priority_ordered_id_list: directed and random request traffic
// in bursts, with priority_ordered_id_list_checker alongside. Depends on pol_pkg.
module priority_ordered_id_list_tb;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   pol_pkg::req_type req_data;
   logic             rsp_valid;
   pol_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending;

   priority_ordered_id_list dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   priority_ordered_id_list_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #4 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic pol_pkg::req_type make_req(pol_pkg::func_type f, logic [31:0] id,
                                                 logic [31:0] prio);
      pol_pkg::req_type r;
      r.func = f;
      r.page_id = id;
      r.priority_req = prio;
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic issue(pol_pkg::req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   initial begin
      int                burst;
      int                gap;
      int                k;
      int                sent;
      int                pick;
      logic              draining;
      logic [31:0]       id;
      logic [31:0]       prio;
      pol_pkg::func_type f;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // remove from an empty list, field extremes, ties, re-register
      issue(make_req(pol_pkg::FUNC_REMOVE, 32'h5, 32'h0));
      issue(make_req(pol_pkg::FUNC_REGISTER, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
      issue(make_req(pol_pkg::FUNC_REGISTER, 32'h0, 32'h8000_0000));
      issue(make_req(pol_pkg::FUNC_REGISTER, 32'h1, 32'h0));
      issue(make_req(pol_pkg::FUNC_REGISTER, 32'h2, 32'h0));
      issue(make_req(pol_pkg::FUNC_REGISTER, 32'h0, 32'h0));
      issue(make_req(pol_pkg::FUNC_REMOVE, 32'h1, 32'h0));
      issue(make_req(pol_pkg::FUNC_REMOVE, 32'h77, 32'h0));
      // fill to capacity, then a new id (dropped) and an existing one (accepted)
      for (k = 0; k < 13; k++)
         issue(make_req(pol_pkg::FUNC_REGISTER, 32'h100 + k, k % 4 - 2));
      issue(make_req(pol_pkg::FUNC_REGISTER, 32'hABCD, 32'h1));
      issue(make_req(pol_pkg::FUNC_REGISTER, 32'h2, -5));
      issue(make_req(pol_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0));
      issue(make_req(pol_pkg::FUNC_REMOVE, 32'h2, 32'h0));

      // random traffic: fill and drain phases over a small id pool so that
      // hits, re-registers and full-list drops all occur often
      sent = 0;
      draining = 1'b0;
      while (sent < 400) begin
         if ($urandom_range(0, 5) == 0) burst = $urandom_range(30, 60);
         else burst = $urandom_range(1, 12);
         for (k = 0; k < burst && sent < 400; k++) begin
            if ($urandom_range(0, 99) < (draining ? 60 : 20)) f = pol_pkg::FUNC_REMOVE;
            else f = pol_pkg::FUNC_REGISTER;
            if ($urandom_range(0, 9) == 0) begin
               id = $urandom;
            end else begin
               pick = $urandom_range(0, 11);
               if ($urandom_range(0, 1)) id = pick;
               else id = 32'hFFFF_FFF0 - pick;
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: prio = $urandom_range(0, 6) - 3;
               5, 6, 7:       prio = $urandom;
               8:             prio = 32'h8000_0000;
               default:       prio = 32'h7FFF_FFFF;
            endcase
            issue(make_req(f, id, prio));
            sent++;
         end
         if ($urandom_range(0, 3) == 0) draining = !draining;
         gap = $urandom_range(1, 40);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end

      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/pol_pkg.sv
rtl/pol_ram.sv
rtl/priority_ordered_id_list.sv
tb/priority_ordered_id_list_checker.sv
tb/priority_ordered_id_list_tb.sv
